### rtl/core/lpt_pkg.sv
// shared types, codes and sizes for the listen port table
package lpt_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam int OP_W     = 2;
    localparam int HANDLE_W = 8;
    localparam int PORT_W   = 16;
    localparam int STATUS_W = 2;

    // request tdata: conn_handle, port_number
    localparam int S_TDATA_W = 24;
    // result tdata: status, found, zero pad
    localparam int M_TDATA_W = 8;

    localparam logic [OP_W-1:0] OP_LISTEN   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNLISTEN = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INUSE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTLIST = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture the request beat
        logic commit;  // apply the request to the table and latch the result
    } t_dp_cmd;

endpackage

### rtl/core/lpt_ctrl.sv
// controller: request sequencing and result beat handshake
module lpt_ctrl
    import lpt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_dp_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic w_out_free;

    // result register can take a new beat when empty or being drained
    assign w_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

### rtl/core/lpt_datapath.sv
// datapath: slot table, parallel compare, lowest slot select and result register
module lpt_datapath
    import lpt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [HANDLE_W-1:0] i_conn_handle,
    input  logic [PORT_W-1:0]   i_port_number,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_found
);

    logic [OP_W-1:0]     r_op;
    logic [HANDLE_W-1:0] r_handle;
    logic [PORT_W-1:0]   r_port;

    logic [SLOT_COUNT-1:0] r_valid;
    logic [HANDLE_W-1:0]   r_slot_handle [SLOT_COUNT];
    logic [PORT_W-1:0]     r_slot_port   [SLOT_COUNT];

    logic [STATUS_W-1:0] r_status;
    logic                r_found;

    logic [SLOT_COUNT-1:0] w_port_hit;
    logic [SLOT_COUNT-1:0] w_handle_hit;
    logic [SLOT_COUNT-1:0] w_free;
    logic [SLOT_COUNT-1:0] w_free_sel;
    logic [SLOT_COUNT-1:0] w_handle_sel;
    logic [SLOT_COUNT-1:0] w_one;
    logic                  w_port_any;
    logic                  w_do_fill;
    logic                  w_do_free;
    logic [STATUS_W-1:0]   w_status;
    logic                  w_found;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_handle <= i_conn_handle;
            r_port   <= i_port_number;
        end
    end

    // every slot compares against the held request in parallel
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            w_port_hit[i]   = r_valid[i] && (r_slot_port[i] == r_port);
            w_handle_hit[i] = r_valid[i] && (r_slot_handle[i] == r_handle);
        end
    end

    assign w_one      = SLOT_COUNT'(1);
    assign w_free     = ~r_valid;
    // isolate the lowest set bit
    assign w_free_sel   = w_free & (~w_free + w_one);
    assign w_handle_sel = w_handle_hit & (~w_handle_hit + w_one);
    assign w_port_any   = |w_port_hit;

    always_comb begin
        w_status  = ST_OK;
        w_found   = 1'b0;
        w_do_fill = 1'b0;
        w_do_free = 1'b0;
        case (r_op)
            OP_LISTEN: begin
                if (w_port_any) begin
                    w_status = ST_INUSE;
                end else if (!(|w_free)) begin
                    w_status = ST_FULL;
                end else begin
                    w_do_fill = 1'b1;
                end
            end
            OP_UNLISTEN: begin
                if (|w_handle_hit) begin
                    w_do_free = 1'b1;
                end else begin
                    w_status = ST_NOTLIST;
                end
            end
            OP_QUERY: begin
                w_found = w_port_any;
            end
            OP_UNUSED: begin
                w_status = ST_OK;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.commit) begin
            if (w_do_fill) begin
                r_valid <= r_valid | w_free_sel;
            end else if (w_do_free) begin
                r_valid <= r_valid & ~w_handle_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (i_cmd.commit && w_do_fill && w_free_sel[i]) begin
                r_slot_handle[i] <= r_handle;
                r_slot_port[i]   <= r_port;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= w_status;
            r_found  <= w_found;
        end
    end

    assign o_status = r_status;
    assign o_found  = r_found;

endmodule

### rtl/core/listen_port_table_core.sv
// top level of the listen port table
//
// channel   dir  handshake              tdata / tuser
// request   in   i_s_tvalid/o_s_tready  tuser opcode, tdata handle and port
// result    out  o_m_tvalid/i_m_tready  tdata status and found
//
// an item is handled in order: the request beat is captured first, then
// every slot compares in parallel and the lowest matching or free slot is
// updated. the result waits in an output register, so a stalled result
// beat only holds the block once a second result is ready to be written.
// reset clears every slot valid mark at once; handles and ports are not reset.
module listen_port_table_core
    import lpt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // [7:0] conn_handle, [23:8] port_number
    input  logic [OP_W-1:0]      i_s_tuser,  // [1:0] opcode
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata   // [1:0] status, [2] found, [7:3] zero
);

    t_dp_cmd             w_cmd;
    logic [STATUS_W-1:0] w_status;
    logic                w_found;

    lpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    lpt_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_opcode      (i_s_tuser),
        .i_conn_handle (i_s_tdata[HANDLE_W-1:0]),
        .i_port_number (i_s_tdata[HANDLE_W+PORT_W-1:HANDLE_W]),
        .o_status      (w_status),
        .o_found       (w_found)
    );

    assign o_m_tdata = {{(M_TDATA_W-STATUS_W-1){1'b0}}, w_found, w_status};

endmodule
